// ===== rtl/core/sam_pkg.sv =====
// Shared types, constants and saturation helper for the square-matrix unit.
package sam_pkg;

  localparam int DIM    = 4;
  localparam int IDX_W  = 2;
  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int ACC_W  = 66;

  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_EXEC = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_SCL = 3'd3,
    OP_DIV = 3'd4,
    OP_EQ  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_ACC,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              en;
    logic              sel_b;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } wr_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [ACC_W-1:0] x);
    sat_t r;
    logic hi_ok;
    hi_ok = (x[ACC_W-1:31] == '0) || (x[ACC_W-1:31] == '1);
    if (hi_ok) begin
      r.value = x[31:0];
      r.ovf   = 1'b0;
    end else if (x[ACC_W-1]) begin
      r.value = 32'h8000_0000;
      r.ovf   = 1'b1;
    end else begin
      r.value = 32'h7FFF_FFFF;
      r.ovf   = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sam_store.sv =====
// Operand stores A and B with per-entry valid bits; unwritten entries read as identity.
module sam_store
  import sam_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wr_req_t           wr,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [31:0]       rd_a,
  output logic [31:0]       rd_b
);

  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic [31:0]      mem_a [CELLS];
  logic [31:0]      mem_b [CELLS];
  logic [CELLS-1:0] vld_a_r;
  logic [CELLS-1:0] vld_b_r;
  logic [31:0]      a_q_r, b_q_r;
  logic             a_v_r, b_v_r, a_d_r, b_d_r;

  always_ff @(posedge clk) begin
    if (wr.en && !wr.sel_b) begin
      mem_a[wr.addr] <= wr.data;
    end
    if (wr.en && wr.sel_b) begin
      mem_b[wr.addr] <= wr.data;
    end
    a_q_r <= mem_a[rd_addr_a];
    b_q_r <= mem_b[rd_addr_b];
    a_d_r <= rd_addr_a[ADDR_W-1:IDX_W] == rd_addr_a[IDX_W-1:0];
    b_d_r <= rd_addr_b[ADDR_W-1:IDX_W] == rd_addr_b[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= '0;
      vld_b_r <= '0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
    end else begin
      if (wr.en && !wr.sel_b) begin
        vld_a_r[wr.addr] <= 1'b1;
      end
      if (wr.en && wr.sel_b) begin
        vld_b_r[wr.addr] <= 1'b1;
      end
      a_v_r <= vld_a_r[rd_addr_a];
      b_v_r <= vld_b_r[rd_addr_b];
    end
  end

  assign rd_a = a_v_r ? a_q_r : (a_d_r ? ONE : '0);
  assign rd_b = b_v_r ? b_q_r : (b_d_r ? ONE : '0);

endmodule

// ===== rtl/core/sam_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module sam_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, den_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial;
  logic             take;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= take ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/square_matrix_alu_top.sv =====
// Top level: sequencer, shared multiplier and accumulator, result register.
//
//   channel | direction | beat holds
//   in_     | into      | cmd, row/col index, element, op code, scalar
//   out_    | out of    | row, col, value, last/equal/overflow/div-zero flags
//
// Loads write on the accepted beat. Add/sub: READ, EXEC, OUT per element;
// scale adds ACC; multiply: READ, EXEC, ACC per term on the shared multiplier;
// divide: one quotient bit a cycle, divider skipped on a zero scalar; equality
// test: READ, EXEC per element, then one OUT. Synchronous active-low reset
// leaves both matrices at identity. in_stall is high while an execute runs;
// out_stall holds the current result beat and pauses the sequencer.
module square_matrix_alu_top
  import sam_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_row_index,
  input  logic [1:0]  in_col_index,
  input  logic [31:0] in_elem_value,
  input  logic [2:0]  in_op_code,
  input  logic [31:0] in_scalar_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_row,
  output logic [1:0]  out_col,
  output logic [31:0] out_value,
  output logic        out_last_flag,
  output logic        out_equal_flag,
  output logic        out_overflow_flag,
  output logic        out_div_zero_flag
);

  localparam int QW = 32 + FRAC_BITS;
  localparam logic [IDX_W-1:0] IMAX = IDX_W'(DIM - 1);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [31:0]             scal_r, scal_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [63:0]      prod_r, prod_nxt;
  logic                    eq_r, eq_nxt, neg_r, neg_nxt;
  logic [31:0]             val_r, val_nxt;
  logic [1:0]              row_r, row_nxt, col_r, col_nxt;
  logic                    last_r, last_nxt, eqf_r, eqf_nxt;
  logic                    ovf_r, ovf_nxt, dz_r, dz_nxt;

  wr_req_t           wr;
  logic [ADDR_W-1:0] ra_a, ra_b;
  logic [31:0]       rd_a, rd_b;
  logic              div_start, div_done;
  logic [QW-1:0]     div_num, div_quo;
  logic [31:0]       abs_a, abs_s;
  logic              last_cell, in_acc;
  logic signed [32:0]      sum33;
  logic signed [ACC_W-1:0] wide, qx;
  sat_t                    sr;

  sam_store #(.FRAC_BITS(FRAC_BITS)) u_store (
    .clk(clk), .rst_n(rst_n), .wr(wr),
    .rd_addr_a(ra_a), .rd_addr_b(ra_b), .rd_a(rd_a), .rd_b(rd_b)
  );

  sam_div #(.NUM_W(QW), .DEN_W(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(abs_s), .done(div_done), .quo(div_quo)
  );

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign last_cell = (i_r == IMAX) && (j_r == IMAX);

  assign wr.en    = in_acc && (in_cmd == CMD_WR_A || in_cmd == CMD_WR_B);
  assign wr.sel_b = in_cmd == CMD_WR_B;
  assign wr.addr  = {in_row_index, in_col_index};
  assign wr.data  = in_elem_value;

  assign ra_a = (op_r == OP_MUL) ? {i_r, k_r} : {i_r, j_r};
  assign ra_b = (op_r == OP_MUL) ? {k_r, j_r} : {i_r, j_r};

  assign abs_a   = rd_a[31] ? 32'(-rd_a) : rd_a;
  assign abs_s   = scal_r[31] ? 32'(-scal_r) : scal_r;
  assign div_num = {abs_a, {FRAC_BITS{1'b0}}};
  assign qx      = ACC_W'(div_quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    scal_r <= scal_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    eq_r   <= eq_nxt;
    neg_r  <= neg_nxt;
    val_r  <= val_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    last_r <= last_nxt;
    eqf_r  <= eqf_nxt;
    ovf_r  <= ovf_nxt;
    dz_r   <= dz_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    scal_nxt  = scal_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    eq_nxt    = eq_r;
    neg_nxt   = neg_r;
    val_nxt   = val_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    last_nxt  = last_r;
    eqf_nxt   = eqf_r;
    ovf_nxt   = ovf_r;
    dz_nxt    = dz_r;
    div_start = 1'b0;
    sum33     = '0;
    wide      = '0;
    sr        = sat32(wide);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_EXEC && in_op_code <= OP_EQ) begin
          op_nxt    = op_t'(in_op_code);
          scal_nxt  = in_scalar_value;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          eq_nxt    = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        row_nxt  = i_r;
        col_nxt  = j_r;
        last_nxt = last_cell;
        eqf_nxt  = 1'b0;
        dz_nxt   = 1'b0;
        unique case (op_r)
          OP_ADD, OP_SUB: begin
            sum33 = (op_r == OP_ADD) ? {rd_a[31], rd_a} + {rd_b[31], rd_b}
                                     : {rd_a[31], rd_a} - {rd_b[31], rd_b};
            wide      = {{(ACC_W-33){sum33[32]}}, sum33};
            sr        = sat32(wide);
            val_nxt   = sr.value;
            ovf_nxt   = sr.ovf;
            state_nxt = S_OUT;
          end
          OP_MUL, OP_SCL: begin
            prod_nxt  = $signed(rd_a) * $signed(op_r == OP_MUL ? rd_b : scal_r);
            state_nxt = S_ACC;
          end
          OP_DIV: begin
            if (scal_r == '0) begin
              dz_nxt    = 1'b1;
              ovf_nxt   = rd_a != '0;
              val_nxt   = (rd_a == '0) ? '0 : (rd_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
              state_nxt = S_OUT;
            end else begin
              div_start = 1'b1;
              neg_nxt   = rd_a[31] ^ scal_r[31];
              state_nxt = S_DIV;
            end
          end
          default: begin
            if (rd_a != rd_b) begin
              eq_nxt = 1'b0;
            end
            if (last_cell) begin
              eqf_nxt   = eq_nxt;
              val_nxt   = '0;
              ovf_nxt   = 1'b0;
              row_nxt   = '0;
              col_nxt   = '0;
              last_nxt  = 1'b1;
              state_nxt = S_OUT;
            end else begin
              j_nxt     = j_r + 1'b1;
              i_nxt     = (j_r == IMAX) ? i_r + 1'b1 : i_r;
              state_nxt = S_READ;
            end
          end
        endcase
      end
      S_ACC: begin
        wide = acc_r + {{(ACC_W-64){prod_r[63]}}, prod_r};
        sr   = sat32(wide >>> FRAC_BITS);
        if (op_r == OP_MUL && k_r != IMAX) begin
          acc_nxt   = wide;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_READ;
        end else begin
          acc_nxt   = '0;
          k_nxt     = '0;
          val_nxt   = sr.value;
          ovf_nxt   = sr.ovf;
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        wide = neg_r ? -qx : qx;
        sr   = sat32(wide);
        if (div_done) begin
          val_nxt   = sr.value;
          ovf_nxt   = sr.ovf;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            i_nxt     = (j_r == IMAX) ? i_r + 1'b1 : i_r;
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_row           = row_r;
  assign out_col           = col_r;
  assign out_value         = val_r;
  assign out_last_flag     = last_r;
  assign out_equal_flag    = eqf_r;
  assign out_overflow_flag = ovf_r;
  assign out_div_zero_flag = dz_r;

`ifndef SYNTHESIS
  a_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_EXEC && in_op_code <= OP_EQ |=> in_stall)
    else $error("execute beat did not start the sequencer");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_flag && !out_stall |=> !out_valid && !in_stall)
    else $error("block not idle after final result beat");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");
  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero_flag |-> !out_equal_flag)
    else $error("div-zero and equal flags both set");
`endif

endmodule
